@@ sv/ascd_pkg.sv @@
`timescale 1ns / 1ps

package ascd_pkg;

    localparam int MaxWindow = 16;
    localparam int IndexBits = 24;
    localparam int ScoreW    = 16;
    localparam int RegW      = 16;
    localparam int CfgWinW   = 5;
    localparam int CfgIdxW   = 2;

    localparam int RingDepth = 2 * MaxWindow + 1;
    localparam int RingAw    = $clog2(RingDepth);
    localparam int WinW      = $clog2(MaxWindow + 2);
    localparam int CntW      = $clog2(2 * MaxWindow + 1);
    localparam int SumW      = ScoreW + $clog2(2 * MaxWindow);
    localparam int ProdW     = ScoreW + CntW;
    localparam int LhsW      = ProdW + 8;
    localparam int RhsW      = RegW + SumW;
    localparam int InDataW   = ((ScoreW + 7) / 8) * 8;
    localparam int OutDataW  = ((IndexBits + 1 + 7) / 8) * 8;

    localparam logic [CfgIdxW-1:0] CfgWindowWidth    = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgRatioThreshold = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgMinContent     = 2'd2;
    localparam logic [CfgIdxW-1:0] CfgMinSceneLength = 2'd3;

    localparam logic [CfgWinW-1:0] RstWindowWidth    = 5'd2;
    localparam logic [RegW-1:0]    RstRatioThreshold = 16'd768;
    localparam logic [RegW-1:0]    RstMinContent     = 16'd3840;
    localparam logic [RegW-1:0]    RstMinSceneLength = 16'd15;

    typedef struct packed {
        logic [CfgWinW-1:0] window_width;
        logic [RegW-1:0]    ratio_threshold;
        logic [RegW-1:0]    min_content;
        logic [RegW-1:0]    min_scene_length;
    } ascd_cfg_t;

    typedef struct packed {
        logic load;
        logic start;
        logic step;
        logic mul;
        logic emit;
    } ascd_cmd_t;

    typedef struct packed {
        logic lag_lt_w;
        logic last;
        logic d_last;
        logic lag_zero;
        logic out_free;
    } ascd_sts_t;

    function automatic logic [WinW-1:0] eff_width(input logic [CfgWinW-1:0] v);
        logic [WinW-1:0] w;
        if (v == '0) begin
            w = WinW'(1);
        end else if (v > CfgWinW'(MaxWindow)) begin
            w = WinW'(MaxWindow);
        end else begin
            w = WinW'(v);
        end
        return w;
    endfunction

    function automatic logic [RingAw-1:0] ring_addr(input logic [RingAw-1:0] head,
                                                    input logic [RingAw-1:0] back);
        logic [RingAw:0] t;
        t = {1'b0, head} - {1'b0, back};
        if (t[RingAw]) begin
            t = t + (RingAw + 1)'(RingDepth);
        end
        return t[RingAw-1:0];
    endfunction

endpackage

@@ sv/ascd_ram.sv @@
`timescale 1ns / 1ps

module ascd_ram #(
    parameter int DataW = 16,
    parameter int Depth = 33
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [DataW-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr_a,
    output logic [DataW-1:0]         rdata_a,
    input  logic [$clog2(Depth)-1:0] raddr_b,
    output logic [DataW-1:0]         rdata_b
);

    logic [DataW-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

@@ sv/ascd_ctrl.sv @@
`timescale 1ns / 1ps

module ascd_ctrl
    import ascd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  ascd_sts_t sts,
    output ascd_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SUM,
        ST_DRAIN,
        ST_MUL,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (!sts.last && sts.lag_lt_w) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.start  = 1'b1;
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                cmd.step = 1'b1;
                if (sts.d_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = sts.lag_zero ? ST_IDLE : ST_CHECK;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule

@@ sv/ascd_dp.sv @@
`timescale 1ns / 1ps

module ascd_dp
    import ascd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ascd_cfg_t            cfg,
    input  ascd_cmd_t            cmd,
    output ascd_sts_t            sts,
    input  logic [ScoreW-1:0]    in_score,
    input  logic                 in_last,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [IndexBits-1:0] out_frame_index,
    output logic                 out_is_cut,
    output logic                 out_final
);

    logic [RingAw-1:0]    head_reg, head_next;
    logic [IndexBits-1:0] frames_reg, frames_next;
    logic [IndexBits-1:0] next_idx_reg, next_idx_next;
    logic [RegW-1:0]      skip_reg, skip_next;
    logic                 last_reg, last_next;
    logic [WinW-1:0]      w_reg, w_next;
    logic [WinW-1:0]      lag_reg, lag_next;
    logic [WinW-1:0]      d_reg, d_next;
    logic                 cur_ld_reg, cur_ld_next;
    logic                 a_vld_reg, a_vld_next;
    logic                 b_vld_reg, b_vld_next;
    logic                 mv_reg, mv_next;

    logic [ScoreW-1:0]    cur_reg, cur_next;
    logic [SumW-1:0]      sum_reg, sum_next;
    logic [CntW-1:0]      cnt_reg, cnt_next;
    logic [LhsW-1:0]      lhs_reg, lhs_next;
    logic [RhsW-1:0]      rhs_reg, rhs_next;
    logic                 hot_reg, hot_next;
    logic [IndexBits-1:0] mi_reg, mi_next;
    logic                 mc_reg, mc_next;
    logic                 mf_reg, mf_next;

    logic [IndexBits-1:0] lag_full;
    logic                 a_ok, b_ok;
    logic [RingAw-1:0]    back_a, back_b, wr_addr, raddr_a, raddr_b;
    logic [ScoreW-1:0]    rd_a, rd_b;
    logic [ProdW-1:0]     prod;
    logic                 out_free, cut;

    assign lag_full = frames_reg - IndexBits'(1) - next_idx_reg;
    assign a_ok     = IndexBits'(d_reg) <= next_idx_reg;
    assign b_ok     = d_reg <= lag_reg;
    assign back_a   = RingAw'(lag_reg) + RingAw'(d_reg);
    assign back_b   = b_ok ? RingAw'(lag_reg - d_reg) : '0;
    assign wr_addr  = (head_reg == RingAw'(RingDepth - 1)) ? '0 : head_reg + RingAw'(1);
    assign raddr_a  = cmd.start ? ring_addr(head_reg, RingAw'(lag_full[WinW-1:0]))
                                : ring_addr(head_reg, back_a);
    assign raddr_b  = ring_addr(head_reg, back_b);
    assign out_free = !mv_reg || out_ready;
    assign prod     = ProdW'(cur_reg) * ProdW'(cnt_reg);
    assign cut      = (skip_reg == '0) && (RhsW'(lhs_reg) > rhs_reg) && hot_reg;

    ascd_ram #(
        .DataW(ScoreW),
        .Depth(RingDepth)
    ) u_ring (
        .aclk   (aclk),
        .we     (cmd.load),
        .waddr  (wr_addr),
        .wdata  (in_score),
        .raddr_a(raddr_a),
        .rdata_a(rd_a),
        .raddr_b(raddr_b),
        .rdata_b(rd_b)
    );

    always_comb begin
        head_next     = head_reg;
        frames_next   = frames_reg;
        next_idx_next = next_idx_reg;
        skip_next     = skip_reg;
        last_next     = last_reg;
        w_next        = w_reg;
        lag_next      = lag_reg;
        d_next        = d_reg;
        cur_ld_next   = 1'b0;
        a_vld_next    = 1'b0;
        b_vld_next    = 1'b0;
        mv_next       = mv_reg;
        cur_next      = cur_ld_reg ? rd_a : cur_reg;
        sum_next      = sum_reg + (a_vld_reg ? SumW'(rd_a) : '0)
                                + (b_vld_reg ? SumW'(rd_b) : '0);
        cnt_next      = cnt_reg + CntW'(a_vld_reg) + CntW'(b_vld_reg);
        lhs_next      = lhs_reg;
        rhs_next      = rhs_reg;
        hot_next      = hot_reg;
        mi_next       = mi_reg;
        mc_next       = mc_reg;
        mf_next       = mf_reg;

        if (cmd.load) begin
            head_next   = wr_addr;
            frames_next = frames_reg + IndexBits'(1);
            last_next   = in_last;
            w_next      = eff_width(cfg.window_width);
        end
        if (cmd.start) begin
            lag_next    = lag_full[WinW-1:0];
            d_next      = WinW'(1);
            sum_next    = '0;
            cnt_next    = '0;
            cur_ld_next = 1'b1;
        end
        if (cmd.step) begin
            a_vld_next = a_ok;
            b_vld_next = b_ok;
            d_next     = d_reg + WinW'(1);
        end
        if (cmd.mul) begin
            lhs_next = {prod, 8'b0};
            rhs_next = RhsW'(cfg.ratio_threshold) * RhsW'(sum_reg);
            hot_next = cur_reg > cfg.min_content;
        end
        if (cmd.emit) begin
            mv_next = 1'b1;
            mi_next = next_idx_reg;
            mc_next = cut;
            mf_next = last_reg && (lag_reg == '0);
            if (skip_reg != '0) begin
                skip_next = skip_reg - RegW'(1);
            end else if (cut) begin
                skip_next = cfg.min_scene_length;
            end
            if (last_reg && (lag_reg == '0)) begin
                frames_next   = '0;
                next_idx_next = '0;
                skip_next     = '0;
            end else begin
                next_idx_next = next_idx_reg + IndexBits'(1);
            end
        end else if (mv_reg && out_ready) begin
            mv_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg     <= RingAw'(RingDepth - 1);
            frames_reg   <= '0;
            next_idx_reg <= '0;
            skip_reg     <= '0;
            last_reg     <= 1'b0;
            w_reg        <= WinW'(1);
            lag_reg      <= '0;
            d_reg        <= '0;
            cur_ld_reg   <= 1'b0;
            a_vld_reg    <= 1'b0;
            b_vld_reg    <= 1'b0;
            mv_reg       <= 1'b0;
        end else begin
            head_reg     <= head_next;
            frames_reg   <= frames_next;
            next_idx_reg <= next_idx_next;
            skip_reg     <= skip_next;
            last_reg     <= last_next;
            w_reg        <= w_next;
            lag_reg      <= lag_next;
            d_reg        <= d_next;
            cur_ld_reg   <= cur_ld_next;
            a_vld_reg    <= a_vld_next;
            b_vld_reg    <= b_vld_next;
            mv_reg       <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        sum_reg <= sum_next;
        cnt_reg <= cnt_next;
        lhs_reg <= lhs_next;
        rhs_reg <= rhs_next;
        hot_reg <= hot_next;
        mi_reg  <= mi_next;
        mc_reg  <= mc_next;
        mf_reg  <= mf_next;
    end

    assign sts.lag_lt_w = lag_full < IndexBits'(w_reg);
    assign sts.last     = last_reg;
    assign sts.d_last   = (d_reg == w_reg);
    assign sts.lag_zero = (lag_reg == '0);
    assign sts.out_free = out_free;

    assign out_valid       = mv_reg;
    assign out_frame_index = mi_reg;
    assign out_is_cut      = mc_reg;
    assign out_final       = mf_reg;

endmodule

@@ sv/adaptive_shot_cut_detector.sv @@
// A frame is decided once as many later frames arrive as the effective width w, or at once on the last;
// each decision runs check, the neighbor-sum loop over the 33-entry ring, drain, multiply and emit,
// and waits in emit while the previous word waits on m_tready. A score holds the input until every
// decision it releases is emitted, so a new score is taken only once the work on the last is done.
// Synchronous reset clears counters, holdoff and output valid and loads register defaults.
`timescale 1ns / 1ps

module adaptive_shot_cut_detector
    import ascd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CfgIdxW-1:0]    cfg_index,
    input  logic [RegW-1:0]       cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [InDataW-1:0]    s_tdata,   // [15:0] score
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OutDataW-1:0]   m_tdata,   // [23:0] frame_index, [24] is_cut
    output logic                  m_tlast
);

    ascd_cfg_t            cfg_reg, cfg_next;
    ascd_cmd_t            cmd;
    ascd_sts_t            sts;
    logic [IndexBits-1:0] frame_index;
    logic                 is_cut;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CfgWindowWidth:    cfg_next.window_width     = cfg_wdata[CfgWinW-1:0];
                CfgRatioThreshold: cfg_next.ratio_threshold  = cfg_wdata;
                CfgMinContent:     cfg_next.min_content      = cfg_wdata;
                CfgMinSceneLength: cfg_next.min_scene_length = cfg_wdata;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.window_width     <= RstWindowWidth;
            cfg_reg.ratio_threshold  <= RstRatioThreshold;
            cfg_reg.min_content      <= RstMinContent;
            cfg_reg.min_scene_length <= RstMinSceneLength;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    ascd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_valid(s_tvalid),
        .in_ready(s_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ascd_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .cmd            (cmd),
        .sts            (sts),
        .in_score       (s_tdata[ScoreW-1:0]),
        .in_last        (s_tlast),
        .out_ready      (m_tready),
        .out_valid      (m_tvalid),
        .out_frame_index(frame_index),
        .out_is_cut     (is_cut),
        .out_final      (m_tlast)
    );

    assign m_tdata = OutDataW'({is_cut, frame_index});

`ifndef ASSERT_OFF
    a_emit_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> sts.out_free)
        else $error("Decision issued while the output word is still held.");

    a_start_released: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |-> (sts.last || !sts.lag_lt_w))
        else $error("Decision started for a frame that is not yet released.");

    a_one_word_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("New score accepted while the previous one is still in work.");
`endif

endmodule
